[rtl/far_pkg.sv]
package far_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int NUM_WIDTH = 2 * IN_WIDTH + 1;
    localparam int DEN_WIDTH = 2 * IN_WIDTH;
    localparam int MAG_WIDTH = 2 * IN_WIDTH;
    localparam int CNT_WIDTH = $clog2(MAG_WIDTH + 1);

    typedef struct packed {
        logic signed [NUM_WIDTH-1:0] num;
        logic signed [DEN_WIDTH-1:0] den;
    } frac_t;

endpackage

[rtl/far_front.sv]
module far_front
    import far_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [IN_WIDTH-1:0]  s_a_num,
    input  logic signed [IN_WIDTH-1:0]  s_a_den,
    input  logic signed [IN_WIDTH-1:0]  s_b_num,
    input  logic signed [IN_WIDTH-1:0]  s_b_den,
    output logic                        q_valid,
    input  logic                        q_ready,
    output frac_t                       q_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic signed [IN_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [DEN_WIDTH-1:0] p0_reg, p1_reg, den_reg;
    frac_t out_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign q_valid = (state_reg == ST_OUT);
    assign q_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        an_reg    <= s_a_num;
                        ad_reg    <= s_a_den;
                        bn_reg    <= s_b_num;
                        bd_reg    <= s_b_den;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    p0_reg    <= an_reg * bd_reg;
                    p1_reg    <= ad_reg * bn_reg;
                    den_reg   <= ad_reg * bd_reg;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    out_reg.num <= NUM_WIDTH'(p0_reg) + NUM_WIDTH'(p1_reg);
                    out_reg.den <= den_reg;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (q_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/far_queue.sv]
module far_queue
    import far_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  frac_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output frac_t out_data
);

    frac_t       mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr, rd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) begin
                wp_reg <= ~wp_reg;
            end
            if (rd) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

[rtl/far_back.sv]
module far_back
    import far_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  frac_t                        q_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [NUM_WIDTH-1:0]  m_sum_num,
    output logic signed [DEN_WIDTH-1:0]  m_sum_den
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    frac_t                   in_reg;
    logic [MAG_WIDTH-1:0]    x_reg, y_reg;
    logic [CNT_WIDTH-1:0]    k_reg, bit_reg;
    logic [MAG_WIDTH-1:0]    quo_reg, rem_reg, div_reg;
    logic                    neg_reg;
    logic [MAG_WIDTH-1:0]    mag_num, mag_den, diff, rem_sh;
    logic [MAG_WIDTH-1:0]    num_res_reg;
    logic signed [NUM_WIDTH-1:0] num_out_reg;
    logic signed [DEN_WIDTH-1:0] den_out_reg;

    assign q_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_sum_num = num_out_reg;
    assign m_sum_den = den_out_reg;

    // magnitudes fit 32 bits: |num| <= 2^31
    assign mag_num = q_data.num[NUM_WIDTH-1] ? MAG_WIDTH'(-q_data.num)
                                             : MAG_WIDTH'(q_data.num);
    assign mag_den = q_data.den[DEN_WIDTH-1] ? MAG_WIDTH'(-q_data.den)
                                             : MAG_WIDTH'(q_data.den);
    assign diff    = (x_reg > y_reg) ? x_reg - y_reg : y_reg - x_reg;
    assign rem_sh  = {rem_reg[MAG_WIDTH-2:0], quo_reg[MAG_WIDTH-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        in_reg <= q_data;
                        x_reg  <= mag_num;
                        y_reg  <= mag_den;
                        k_reg  <= '0;
                        if (mag_num == '0 || mag_den == '0) begin
                            num_out_reg <= q_data.num;
                            den_out_reg <= q_data.den;
                            state_reg   <= ST_OUT;
                        end else begin
                            state_reg <= ST_GCD;
                        end
                    end
                end
                // binary gcd, one step a cycle
                ST_GCD: begin
                    if (x_reg == y_reg) begin
                        div_reg <= x_reg << k_reg;
                        quo_reg <= in_reg.num[NUM_WIDTH-1] ? MAG_WIDTH'(-in_reg.num)
                                                           : MAG_WIDTH'(in_reg.num);
                        neg_reg <= in_reg.num[NUM_WIDTH-1];
                        rem_reg <= '0;
                        bit_reg <= '0;
                        state_reg <= ST_DIVN;
                    end else if (!x_reg[0] && !y_reg[0]) begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end else if (!x_reg[0]) begin
                        x_reg <= x_reg >> 1;
                    end else if (!y_reg[0]) begin
                        y_reg <= y_reg >> 1;
                    end else if (x_reg > y_reg) begin
                        x_reg <= diff >> 1;
                    end else begin
                        y_reg <= diff >> 1;
                    end
                end
                // restoring division, one bit a cycle
                ST_DIVN, ST_DIVD: begin
                    if (rem_sh >= div_reg) begin
                        rem_reg <= rem_sh - div_reg;
                        quo_reg <= {quo_reg[MAG_WIDTH-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[MAG_WIDTH-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == CNT_WIDTH'(MAG_WIDTH - 1)) begin
                        bit_reg <= '0;
                        rem_reg <= '0;
                        if (state_reg == ST_DIVN) begin
                            num_res_reg <= {quo_reg[MAG_WIDTH-2:0],
                                            rem_sh >= div_reg};
                            quo_reg <= in_reg.den[DEN_WIDTH-1]
                                     ? MAG_WIDTH'(-in_reg.den) : MAG_WIDTH'(in_reg.den);
                            state_reg <= ST_DIVD;
                        end else begin
                            num_out_reg <= neg_reg
                                ? -NUM_WIDTH'(num_res_reg) : NUM_WIDTH'(num_res_reg);
                            den_out_reg <= in_reg.den[DEN_WIDTH-1]
                                ? -DEN_WIDTH'({quo_reg[MAG_WIDTH-2:0], rem_sh >= div_reg})
                                : DEN_WIDTH'({quo_reg[MAG_WIDTH-2:0], rem_sh >= div_reg});
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/fraction_add_reduce.sv]
// fraction_add_reduce: adds a_num/a_den and b_num/b_den and reduces the sum by
// the gcd of the magnitudes; zero numerator or denominator passes unreduced and
// signs are kept as the products give them. A front unit forms the products
// and their sum in its MUL1 and MUL2 states and hands the fraction through a
// two-entry queue to a back unit that runs a binary gcd and two bit-serial
// divisions; a zero numerator or denominator skips both.
module fraction_add_reduce
    import far_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [IN_WIDTH-1:0]   s_a_num,
    input  logic signed [IN_WIDTH-1:0]   s_a_den,
    input  logic signed [IN_WIDTH-1:0]   s_b_num,
    input  logic signed [IN_WIDTH-1:0]   s_b_den,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [NUM_WIDTH-1:0]  m_sum_num,
    output logic signed [DEN_WIDTH-1:0]  m_sum_den
);

    logic  f_valid, f_ready, b_valid, b_ready;
    frac_t f_data, b_data;

    far_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_a_num, .s_a_den, .s_b_num, .s_b_den,
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    far_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
    );

    far_back u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .m_valid, .m_ready, .m_sum_num, .m_sum_den
    );

endmodule

[sim/tb.sv]
module tb;
    import far_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [IN_WIDTH-1:0] an;
        logic signed [IN_WIDTH-1:0] ad;
        logic signed [IN_WIDTH-1:0] bn;
        logic signed [IN_WIDTH-1:0] bd;
        logic                       known;
        logic signed [NUM_WIDTH-1:0] enum_v;
        logic signed [DEN_WIDTH-1:0] eden_v;
    } frac_row_t;

    localparam logic signed [IN_WIDTH-1:0] SMAX = {1'b0, {(IN_WIDTH-1){1'b1}}};
    localparam logic signed [IN_WIDTH-1:0] SMIN = {1'b1, {(IN_WIDTH-1){1'b0}}};
    localparam int N_RANDOM   = 1030;
    localparam int CYCLE_CAP  = 600000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [IN_WIDTH-1:0] s_a_num, s_a_den, s_b_num, s_b_den;
    logic m_valid;
    logic m_ready;
    logic signed [NUM_WIDTH-1:0] m_sum_num;
    logic signed [DEN_WIDTH-1:0] m_sum_den;

    frac_t sum_queue[$];
    int errors = 0;
    int sums_seen = 0;
    int cycles = 0;
    bit drive_done = 0;
    bit hold_off = 0;
    bit calm = 0;

    fraction_add_reduce DUT (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("%0t timeout", $time);
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic frac_t reduced_sum(logic signed [IN_WIDTH-1:0] an,
                                          logic signed [IN_WIDTH-1:0] ad,
                                          logic signed [IN_WIDTH-1:0] bn,
                                          logic signed [IN_WIDTH-1:0] bd);
        longint n, d;
        longint unsigned g;
        frac_t r;
        n = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
        d = longint'(ad) * longint'(bd);
        if (n != 0 && d != 0) begin
            g = gcd_mag(n < 0 ? -n : n, d < 0 ? -d : d);
            if (g > 1) begin
                n = n / longint'(g);
                d = d / longint'(g);
            end
        end
        r.num = n[NUM_WIDTH-1:0];
        r.den = d[DEN_WIDTH-1:0];
        return r;
    endfunction

    task automatic offer(input frac_row_t row);
        frac_t p;
        p = reduced_sum(row.an, row.ad, row.bn, row.bd);
        if (row.known && (p.num !== row.enum_v || p.den !== row.eden_v)) begin
            $display("%0t table row disagrees: expected %0d/%0d predicted %0d/%0d",
                     $time, row.enum_v, row.eden_v, p.num, p.den);
            errors++;
        end
        if (row.known) begin
            p.num = row.enum_v;
            p.den = row.eden_v;
        end
        while (!calm && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_a_num <= row.an;
        s_a_den <= row.ad;
        s_b_num <= row.bn;
        s_b_den <= row.bd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sum_queue.push_back(p);
    endtask

    function automatic logic signed [IN_WIDTH-1:0] rand_field();
        case ($urandom_range(7))
            0: return SMAX;
            1: return SMIN;
            2: return '0;
            3: return IN_WIDTH'($urandom_range(8) - 4);
            4: return IN_WIDTH'($urandom_range(60) - 30);
            default: return IN_WIDTH'($urandom);
        endcase
    endfunction

    function automatic frac_row_t row_of(int an, int ad, int bn, int bd, bit known,
                                         longint en = 0, longint ed = 0);
        frac_row_t r;
        r.an = IN_WIDTH'(an); r.ad = IN_WIDTH'(ad);
        r.bn = IN_WIDTH'(bn); r.bd = IN_WIDTH'(bd);
        r.known = known;
        r.enum_v = NUM_WIDTH'(en);
        r.eden_v = DEN_WIDTH'(ed);
        return r;
    endfunction

    initial begin
        frac_row_t rows[$];
        frac_row_t r;
        int k;
        aresetn = 0;
        s_valid = 0;
        s_a_num = 0; s_a_den = 0; s_b_num = 0; s_b_den = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back(row_of(1, 2, 1, 2, 1, 1, 1));
        rows.push_back(row_of(1, 3, 1, 6, 1, 1, 2));
        rows.push_back(row_of(0, 5, 0, 7, 1, 0, 35));
        rows.push_back(row_of(3, 0, 4, 5, 1, 15, 0));
        rows.push_back(row_of(1, 2, -1, 2, 1, 0, 4));
        rows.push_back(row_of(-1, 2, -1, 2, 1, -1, 1));
        rows.push_back(row_of(1, -2, 1, -2, 1, -1, 1));
        rows.push_back(row_of(1, 2, 1, -2, 1, 0, -4));
        rows.push_back(row_of(-32768, -32768, -32768, -32768, 1, 2, 1));
        rows.push_back(row_of(-32768, 1, -32768, 1, 1, -65536, 1));
        rows.push_back(row_of(-32768, -32768, 32767, -32768, 1, 1, 32768));
        rows.push_back(row_of(32767, 32767, 32767, 32767, 1, 2, 1));
        rows.push_back(row_of(-32768, 32767, -32768, 32767, 1, -65536, 32767));
        rows.push_back(row_of(0, 0, 0, 0, 1, 0, 0));
        rows.push_back(row_of(7, 13, 11, 17, 0));
        rows.push_back(row_of(-21, 6, 35, -10, 0));
        rows.push_back(row_of(32767, -32768, -32768, 32767, 0));
        rows.push_back(row_of(-1, -1, -1, -1, 0));
        rows.push_back(row_of(21845, -21846, 10922, 5461, 0));
        rows.push_back(row_of(-21846, 21845, -10923, -5462, 0));
        foreach (rows[i]) offer(rows[i]);

        for (k = 0; k < N_RANDOM; k++) begin
            calm = (k >= 300 && k < 420);
            r.an = rand_field(); r.ad = rand_field();
            r.bn = rand_field(); r.bd = rand_field();
            r.known = 0;
            offer(r);
        end
        s_valid <= 1'b0;
        drive_done = 1;
    end

    // long receiver stall so the pipeline backs up
    initial begin
        int n;
        wait (aresetn);
        repeat (3000) @(posedge aclk);
        hold_off = 1;
        for (n = 0; n < 1500; n++) @(posedge aclk);
        hold_off = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && (calm || $urandom_range(99) >= 14);
        end
    end

    always @(posedge aclk) begin
        frac_t want;
        if (aresetn && m_valid && m_ready) begin
            sums_seen++;
            if (sum_queue.size() == 0) begin
                $display("%0t unexpected transaction: actual %0d/%0d",
                         $time, m_sum_num, m_sum_den);
                errors++;
            end else begin
                want = sum_queue.pop_front();
                if (m_sum_num !== want.num) begin
                    $display("%0t sum_num expected %0d actual %0d",
                             $time, want.num, m_sum_num);
                    errors++;
                end
                if (m_sum_den !== want.den) begin
                    $display("%0t sum_den expected %0d actual %0d",
                             $time, want.den, m_sum_den);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (drive_done);
        while (sum_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("covered %0d sums incl. extremes, zero and sign cases, long output stall",
                 sums_seen);
        if (errors == 0 && sum_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
